// ----- src/i8mvm_pkg.sv -----
// Shared types, codes and a helper function of the int8 matrix-vector MAC.
`timescale 1ns / 1ps
`default_nettype none

package i8mvm_pkg;

    // Widths fixed by the word formats
    localparam int VAL_W     = 8;
    localparam int VIDX_W    = 10;
    localparam int SUM_W     = 26;
    localparam int ROWNUM_W  = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 4;
    localparam int CNT_W     = 11;
    localparam int PROD_W    = 2 * VAL_W;

    // Operation codes of an input word
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 4'd1;

    localparam logic [CFG_W-1:0] CFG_RESET_VALUE = 11'd64;

    typedef struct packed {
        logic                     operation;
        logic signed [VAL_W-1:0]  element_value;
        logic [VIDX_W-1:0]        vector_index;
    } item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]  row_sum;
        logic [ROWNUM_W-1:0]      row_number;
        logic                     last_row;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // write the vector store
        logic capture;   // take a weight and read the vector store
        logic mul;       // register the product
        logic acc;       // accumulate and advance the column
        logic emit;      // this accumulate closes a row
        logic cfg_wr;    // configuration write
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic row_done;
    } status_t;

    // A zero setting acts as one, a setting above the bound saturates to it.
    function automatic logic [CFG_W-1:0] clamp_setting(input logic [CFG_W-1:0] v,
                                                       input int bound);
        logic [CFG_W-1:0] r;
        r = v;
        if (r == '0) begin
            r = {{(CFG_W-1){1'b0}}, 1'b1};
        end
        if (32'(r) > bound) begin
            r = CFG_W'(bound);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/i8mvm_ctrl.sv -----
// Controller state machine of the int8 matrix-vector MAC.
`timescale 1ns / 1ps
`default_nettype none

module i8mvm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               operation,
    input  wire logic               cfg_valid,
    input  wire i8mvm_pkg::status_t status,
    output i8mvm_pkg::cmd_t         cmd,
    output logic                    busy,
    output logic                    cfg_ready
);

    import i8mvm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                busy        = 1'b0;
                cfg_ready   = 1'b1;
                cmd.cfg_wr  = cfg_valid;
                cmd.load    = start && (operation == OP_LOAD);
                cmd.capture = start && (operation == OP_WEIGHT);
                if (cmd.capture) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                cmd.emit   = status.row_done;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/i8mvm_dp.sv -----
// Datapath of the int8 matrix-vector MAC: vector store, multiplier, accumulator, counters.
`timescale 1ns / 1ps
`default_nettype none

module i8mvm_dp #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire i8mvm_pkg::cmd_t                      cmd,
    input  wire i8mvm_pkg::item_t                     item,
    input  wire logic [i8mvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [i8mvm_pkg::CFG_W-1:0]          cfg_data,
    output i8mvm_pkg::status_t                        status,
    output logic                                      result_valid,
    output i8mvm_pkg::result_t                        result
);

    import i8mvm_pkg::*;

    localparam int IDX_W = $clog2(MAX_COLS);

    logic signed [VAL_W-1:0] vec_mem [MAX_COLS];

    logic [CFG_W-1:0]        rows_reg;
    logic [CFG_W-1:0]        cols_reg;
    logic [CNT_W-1:0]        col_reg;
    logic [CNT_W-1:0]        row_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [VAL_W-1:0] weight_reg;
    logic signed [VAL_W-1:0] rdata_reg;
    logic                    in_range_reg;
    logic                    prod_ok_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    result_valid_reg;
    result_t                 result_reg;

    logic [31:0]             col_ext;
    logic [31:0]             widx_ext;
    logic [IDX_W-1:0]        raddr;
    logic [IDX_W-1:0]        waddr;
    logic                    wr_ok;
    logic [CNT_W:0]          col_next;
    logic [CNT_W:0]          row_next;
    logic                    last;
    logic signed [SUM_W-1:0] sum_next;
    logic                    restart;

    assign col_ext  = 32'(col_reg);
    assign widx_ext = 32'(item.vector_index);
    assign raddr    = col_ext[IDX_W-1:0];
    assign waddr    = widx_ext[IDX_W-1:0];
    assign wr_ok    = widx_ext < 32'(MAX_COLS);

    assign col_next = {1'b0, col_reg} + (CNT_W+1)'(1);
    assign row_next = {1'b0, row_reg} + (CNT_W+1)'(1);
    assign last     = row_next >= {1'b0, rows_reg};
    assign status.row_done = col_next >= {1'b0, cols_reg};

    assign sum_next = prod_ok_reg ? acc_reg + SUM_W'(prod_reg) : acc_reg;
    assign restart  = cmd.cfg_wr && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));

    // Vector store (one write, one registered read port), weight, product and result
    always_ff @(posedge clk) begin
        if (cmd.load && wr_ok) begin
            vec_mem[waddr] <= item.element_value;
        end
        if (cmd.capture) begin
            rdata_reg  <= vec_mem[raddr];
            weight_reg <= item.element_value;
        end
        if (cmd.mul) begin
            prod_reg <= weight_reg * rdata_reg;
        end
        if (cmd.emit) begin
            result_reg.row_sum    <= sum_next;
            result_reg.row_number <= row_reg[ROWNUM_W-1:0];
            result_reg.last_row   <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rows_reg         <= clamp_setting(CFG_RESET_VALUE, MAX_ROWS);
            cols_reg         <= clamp_setting(CFG_RESET_VALUE, MAX_COLS);
            col_reg          <= '0;
            row_reg          <= '0;
            acc_reg          <= '0;
            in_range_reg     <= 1'b0;
            prod_ok_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end else begin
            result_valid_reg <= cmd.emit;
            if (cmd.capture) begin
                in_range_reg <= col_ext < 32'(MAX_COLS);
            end
            if (cmd.mul) begin
                prod_ok_reg <= in_range_reg;
            end
            if (restart) begin
                if (cfg_index == REG_ROWS) begin
                    rows_reg <= clamp_setting(cfg_data, MAX_ROWS);
                end else begin
                    cols_reg <= clamp_setting(cfg_data, MAX_COLS);
                end
                col_reg <= '0;
                row_reg <= '0;
                acc_reg <= '0;
            end else if (cmd.acc) begin
                if (status.row_done) begin
                    acc_reg <= '0;
                    col_reg <= '0;
                    row_reg <= last ? '0 : row_next[CNT_W-1:0];
                end else begin
                    acc_reg <= sum_next;
                    col_reg <= col_next[CNT_W-1:0];
                end
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- src/int8_matrix_vector_mac.sv -----
// Top level of the signed 8-bit matrix-vector multiply-accumulate engine.
`timescale 1ns / 1ps
`default_nettype none

// Signed 8-bit matrix-vector multiply. A word is taken at a rising edge where
// start is high and busy is low. A load word (operation low) writes one element
// of the vector store and leaves busy low. A weight word (operation high)
// starts the registered read of the vector store at the current column on the
// edge that takes it, and then holds busy high through the multiply state (the
// 8x8 multiply) and the accumulate state, so no new word is taken until the
// weight is through.
// Weights arrive in row-major order; when a row's configured number of columns
// has been accumulated, result_valid is high for exactly one cycle, the cycle
// in which busy falls, with the row's sum, its number and a last-row flag. The
// receiver cannot hold a result off, so it must take it in that cycle.
// Configuration writes are taken while the engine is idle (cfg_ready high);
// writing either register restarts the matrix at row zero, column zero.
// A setting of zero acts as one and a setting above MAX_ROWS or MAX_COLS
// saturates to that bound. Vector elements must be loaded before use.

module int8_matrix_vector_mac #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire i8mvm_pkg::item_t                     item,
    output logic                                      result_valid,
    output i8mvm_pkg::result_t                        result,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [i8mvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [i8mvm_pkg::CFG_W-1:0]          cfg_data
);

    import i8mvm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencing: accept, multiply, accumulate
    i8mvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .cfg_valid (cfg_valid),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready)
    );

    // Vector store, multiplier, accumulator, row and column counters
    i8mvm_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    // A result only ever follows a weight that was being worked on.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without a weight in flight");

    // An accepted weight always makes the engine busy in the next cycle.
    a_weight_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.operation == OP_WEIGHT) |=> busy)
        else $error("weight word accepted without starting work");

    // At most one result per weight, so results never stand back to back.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two result words in consecutive cycles");

    // Configuration is never taken while a weight is being worked on.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("configuration port ready while busy");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the signed 8-bit matrix-vector multiply-accumulate engine.
`timescale 1ns / 1ps

// The stimulus is built up front as a queue of pending words: input words,
// configuration writes and holds. A driver clocked on the falling edge takes
// them from that queue one at a time. A monitor clocked on the rising edge
// does three things. It predicts the rows that each accepted word completes.
// It applies accepted configuration writes to its own copy of the settings.
// It compares every result word, field by field, with the oldest row sum
// still outstanding.

module testbench;

    import i8mvm_pkg::*;

    localparam int VEC_DEPTH     = 1024;
    localparam int ROW_BOUND     = 1024;
    localparam int COL_BOUND     = 1024;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 1050;

    // An index outside the register list; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

    typedef enum logic [1:0] {
        WORD_ITEM,
        WORD_CFG,
        WORD_HOLD
    } word_kind_t;

    typedef struct {
        word_kind_t             kind;
        item_t                  data;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_W-1:0]       reg_value;
        int                     gap;
    } pending_t;

    typedef enum logic [2:0] {
        DRV_FETCH,
        DRV_GAP,
        DRV_SEND,
        DRV_DRAIN,
        DRV_SETTLE,
        DRV_CFG,
        DRV_DONE
    } drv_state_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    item_t                  item;
    logic                   result_valid;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // Stimulus queue and driver state
    pending_t               pending [$];
    pending_t               cur;
    drv_state_t             drv_state;
    int                     gap_left;
    int                     settle_left;
    logic                   in_taken;
    logic                   cfg_taken;

    // Generator's view of the column position and of the loaded entries
    bit                     gen_written [VEC_DEPTH];
    int                     gen_col;
    int                     gen_cols;
    int                     items_made;

    // Prediction state
    logic signed [VAL_W-1:0] m_vec [VEC_DEPTH];
    longint                 m_sum;
    int                     m_col;
    int                     m_row;
    int                     m_rows;
    int                     m_cols;
    result_t                exp_q [$];
    int                     errors;
    int                     cycle_count;

    int8_matrix_vector_mac #(
        .MAX_COLS (COL_BOUND),
        .MAX_ROWS (ROW_BOUND)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A zero setting acts as one, a setting above the bound saturates to it.
    function automatic int clamp_tb(input logic [CFG_W-1:0] v, input int bound);
        int x;
        x = int'(v);
        if (x == 0)
        begin
            x = 1;
        end
        if (x > bound)
        begin
            x = bound;
        end
        return x;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_val();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return 8'sh80;
        end
        else if (pick == 1)
        begin
            return 8'sh7F;
        end
        return VAL_W'($urandom_range(0, 255));
    endfunction

    // ---------------- stimulus building ----------------

    task automatic add_load(input int idx, input logic signed [VAL_W-1:0] val);
        pending_t w;
        w.kind               = WORD_ITEM;
        w.data.operation     = OP_LOAD;
        w.data.element_value = val;
        w.data.vector_index  = VIDX_W'(idx);
        w.reg_index          = '0;
        w.reg_value          = '0;
        w.gap                = $urandom_range(0, 14);
        pending.push_back(w);
        gen_written[idx] = 1'b1;
        items_made = items_made + 1;
    endtask

    task automatic add_weight(input logic signed [VAL_W-1:0] val);
        pending_t w;
        if (!gen_written[gen_col])
        begin
            add_load(gen_col, rand_val());
        end
        w.kind               = WORD_ITEM;
        w.data.operation     = OP_WEIGHT;
        w.data.element_value = val;
        w.data.vector_index  = VIDX_W'($urandom_range(0, VEC_DEPTH - 1));
        w.reg_index          = '0;
        w.reg_value          = '0;
        w.gap                = $urandom_range(0, 14);
        pending.push_back(w);
        items_made = items_made + 1;
        gen_col = gen_col + 1;
        if (gen_col >= gen_cols)
        begin
            gen_col = 0;
        end
    endtask

    task automatic add_hold();
        pending_t w;
        w.kind      = WORD_HOLD;
        w.data      = '0;
        w.reg_index = '0;
        w.reg_value = '0;
        w.gap       = 0;
        pending.push_back(w);
    endtask

    // A configuration write always waits until every result has come.
    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        pending_t w;
        add_hold();
        w.kind      = WORD_CFG;
        w.data      = '0;
        w.reg_index = idx;
        w.reg_value = CFG_W'(val);
        w.gap       = $urandom_range(0, 14);
        pending.push_back(w);
        if ((idx == REG_ROWS) || (idx == REG_COLS))
        begin
            gen_col = 0;
        end
        if (idx == REG_COLS)
        begin
            gen_cols = clamp_tb(CFG_W'(val), COL_BOUND);
        end
    endtask

    initial
    begin : stimulus
        int rows_pick;
        int cols_pick;
        int n;
        int k;
        int pick;
        gen_col    = 0;
        gen_cols   = 64;
        items_made = 0;

        // Settings from reset: full-scale products first
        for (k = 0; k < 64; k++)
        begin
            add_load(k, 8'sh80);
        end
        for (k = 0; k < 64; k++)
        begin
            add_weight(8'sh80);
        end
        for (k = 0; k < 64; k++)
        begin
            add_weight(8'sh7F);
        end
        for (k = 0; k < 10; k++)
        begin
            add_weight(rand_val());
        end
        // A write outside the register list must not restart the row.
        add_cfg(REG_SPARE, 3);
        for (k = 0; k < 60; k++)
        begin
            add_weight(rand_val());
        end

        // Zero settings act as one row of one column.
        add_cfg(REG_ROWS, 0);
        add_cfg(REG_COLS, 0);
        for (k = 0; k < 5; k++)
        begin
            add_weight(rand_val());
        end

        // A row count above the bound saturates.
        add_cfg(REG_ROWS, 2047);
        add_cfg(REG_COLS, 1);
        for (k = 0; k < 6; k++)
        begin
            add_weight(rand_val());
        end

        while (items_made < RANDOM_WORDS)
        begin
            rows_pick = $urandom_range(1, 6);
            cols_pick = $urandom_range(1, 12);
            pick      = $urandom_range(0, 3);
            if (pick == 0)
            begin
                add_cfg(REG_COLS, cols_pick);
            end
            else if (pick == 1)
            begin
                add_cfg(REG_ROWS, rows_pick);
            end
            else if (pick == 2)
            begin
                add_cfg(REG_ROWS, rows_pick);
                add_cfg(REG_COLS, cols_pick);
            end
            else
            begin
                add_cfg(REG_COLS, cols_pick);
                add_cfg(REG_ROWS, rows_pick);
            end
            n = $urandom_range(1, rows_pick * cols_pick * 2 + 2);
            for (k = 0; (k < n) && (items_made < RANDOM_WORDS); k++)
            begin
                pick = $urandom_range(0, 39);
                if (pick < 4)
                begin
                    add_load($urandom_range(0, gen_cols - 1), rand_val());
                end
                else if (pick < 8)
                begin
                    add_load($urandom_range(0, VEC_DEPTH - 1), rand_val());
                end
                else if (pick == 8)
                begin
                    add_hold();
                end
                add_weight(rand_val());
            end
        end
    end

    // ---------------- driver ----------------

    task automatic present(input pending_t w);
        if (w.kind == WORD_ITEM)
        begin
            start     <= 1'b1;
            item      <= w.data;
            cfg_valid <= 1'b0;
            drv_state <= DRV_SEND;
        end
        else
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b1;
            cfg_index <= w.reg_index;
            cfg_data  <= w.reg_value;
            drv_state <= DRV_CFG;
        end
    endtask

    task automatic fetch_next();
        pending_t w;
        if (pending.size() == 0)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
            drv_state <= DRV_DONE;
        end
        else
        begin
            w = pending.pop_front();
            if (w.kind == WORD_HOLD)
            begin
                start     <= 1'b0;
                cfg_valid <= 1'b0;
                drv_state <= DRV_DRAIN;
            end
            else if (w.gap == 0)
            begin
                present(w);
            end
            else
            begin
                start     <= 1'b0;
                cfg_valid <= 1'b0;
                cur       <= w;
                gap_left  <= w.gap;
                drv_state <= DRV_GAP;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            item        <= '0;
            cfg_valid   <= 1'b0;
            cfg_index   <= '0;
            cfg_data    <= '0;
            gap_left    <= 0;
            settle_left <= 0;
            drv_state   <= DRV_FETCH;
        end
        else
        begin
            case (drv_state)
                DRV_FETCH:
                begin
                    fetch_next();
                end
                DRV_GAP:
                begin
                    if (gap_left <= 1)
                    begin
                        present(cur);
                    end
                    else
                    begin
                        gap_left <= gap_left - 1;
                    end
                end
                DRV_SEND:
                begin
                    if (in_taken)
                    begin
                        fetch_next();
                    end
                end
                DRV_CFG:
                begin
                    if (cfg_taken)
                    begin
                        fetch_next();
                    end
                end
                DRV_DRAIN:
                begin
                    if ((exp_q.size() == 0) && !busy)
                    begin
                        settle_left <= SETTLE_CYCLES;
                        drv_state   <= DRV_SETTLE;
                    end
                end
                DRV_SETTLE:
                begin
                    if (settle_left <= 1)
                    begin
                        fetch_next();
                    end
                    else
                    begin
                        settle_left <= settle_left - 1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- prediction ----------------

    task automatic model_restart();
        m_sum = 0;
        m_col = 0;
        m_row = 0;
    endtask

    task automatic model_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
        if (idx == REG_ROWS)
        begin
            m_rows = clamp_tb(val, ROW_BOUND);
            model_restart();
        end
        else if (idx == REG_COLS)
        begin
            m_cols = clamp_tb(val, COL_BOUND);
            model_restart();
        end
    endtask

    task automatic model_step(input item_t w);
        logic    last_w;
        result_t r;
        if (w.operation == OP_LOAD)
        begin
            if (int'(w.vector_index) < VEC_DEPTH)
            begin
                m_vec[w.vector_index] = w.element_value;
            end
        end
        else
        begin
            if (m_col < COL_BOUND)
            begin
                m_sum = m_sum + longint'(w.element_value) * longint'(m_vec[m_col]);
            end
            m_col = m_col + 1;
            if (m_col >= m_cols)
            begin
                last_w       = (m_row + 1 >= m_rows);
                r.row_sum    = SUM_W'(m_sum);
                r.row_number = ROWNUM_W'(m_row);
                r.last_row   = last_w;
                exp_q.push_back(r);
                m_sum = 0;
                m_col = 0;
                m_row = last_w ? 0 : m_row + 1;
            end
        end
    endtask

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin : monitor
        int      i;
        result_t exp_w;
        if (!rst_n)
        begin
            for (i = 0; i < VEC_DEPTH; i++)
            begin
                m_vec[i] = '0;
            end
            m_rows = clamp_tb(CFG_RESET_VALUE, ROW_BOUND);
            m_cols = clamp_tb(CFG_RESET_VALUE, COL_BOUND);
            model_restart();
            exp_q.delete();
            errors      = 0;
            cycle_count <= 0;
            in_taken    <= 1'b0;
            cfg_taken   <= 1'b0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            in_taken    <= start && !busy;
            cfg_taken   <= cfg_valid && cfg_ready;

            if (result_valid)
            begin
                if (exp_q.size() == 0)
                begin
                    $display("%0t: result word, expected none, actual sum %0d row %0d last %0d",
                             $time, result.row_sum, result.row_number, result.last_row);
                    errors = errors + 1;
                end
                else
                begin
                    exp_w = exp_q.pop_front();
                    if (result.row_sum !== exp_w.row_sum)
                    begin
                        $display("%0t: row_sum expected %0d actual %0d",
                                 $time, exp_w.row_sum, result.row_sum);
                        errors = errors + 1;
                    end
                    if (result.row_number !== exp_w.row_number)
                    begin
                        $display("%0t: row_number expected %0d actual %0d",
                                 $time, exp_w.row_number, result.row_number);
                        errors = errors + 1;
                    end
                    if (result.last_row !== exp_w.last_row)
                    begin
                        $display("%0t: last_row expected %0d actual %0d",
                                 $time, exp_w.last_row, result.last_row);
                        errors = errors + 1;
                    end
                end
            end

            if (start && !busy)
            begin
                model_step(item);
            end

            if (cfg_valid && cfg_ready)
            begin
                model_config(cfg_index, cfg_data);
            end

            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ---------------- reset and end of run ----------------

    initial
    begin : run_control
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        while (!((drv_state == DRV_DONE) && (exp_q.size() == 0) && (busy == 1'b0)))
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
